// ===== rtl/core/rws_pkg.sv =====
// Shared constants and types for the Ricker wavelet sample pipeline.
package rws_pkg;

   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int SERIES_TERMS    = 14;
   localparam int SQUARINGS       = 4;

   localparam logic [21:0] PI_Q20        = 22'd3294199;
   localparam logic [27:0] TWO_PI_SQ_Q20 = 28'd20698061;
   localparam logic [30:0] ONE_Q30       = 31'h4000_0000;

   localparam logic [1:0] REG_PEAK_FREQ      = 2'd0;
   localparam logic [1:0] REG_TIME_STEP      = 2'd1;
   localparam logic [1:0] REG_WAVELET_LENGTH = 2'd2;

   // control and payload that ride along the chain
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        zero;
      logic        neg;
      logic [24:0] mag;
   } side_type;

   // series state handed from cell to cell
   typedef struct packed {
      logic [23:0]        a;
      logic [30:0]        term;
      logic signed [32:0] sum;
   } term_bus_type;

endpackage

// ===== rtl/core/rws_term_cell.sv =====
// One Taylor term cell: term = (term*a >> 24) / K, subtracted from the running sum for odd K and added for even K.
module rws_term_cell #(
   parameter int K = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  rws_pkg::term_bus_type bus_i,
   input  rws_pkg::side_type     side_i,
   output rws_pkg::term_bus_type bus_o,
   output rws_pkg::side_type     side_o
);
   import rws_pkg::*;

   localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / K);

   logic [54:0]        pa;
   logic [30:0]        t_in, t_a_ff, t_b_ff, qe_in, qe_b_ff, q;
   logic [62:0]        pb;
   logic [34:0]        qk, rem;
   logic [23:0]        a_a_ff, a_b_ff;
   logic signed [32:0] sum_a_ff, sum_b_ff, sum_in;
   side_type           side_a_ff, side_b_ff, side_c_ff;
   term_bus_type       bus_c_ff, bus_in;

   assign pa    = 55'(bus_i.term) * 55'(bus_i.a);
   assign t_in  = pa[54:24];
   assign pb    = 63'(t_a_ff) * 63'(RECIP);
   assign qe_in = pb[62:32];
   // reciprocal estimate is low by at most one
   assign qk    = 35'(qe_b_ff) * 35'(K);
   assign rem   = 35'(t_b_ff) - qk;
   assign q     = (rem >= 35'(K)) ? qe_b_ff + 31'd1 : qe_b_ff;
   assign sum_in = ((K % 2) == 1) ? sum_b_ff - $signed({2'b00, q})
                                  : sum_b_ff + $signed({2'b00, q});

   always_comb begin
      bus_in.a    = a_b_ff;
      bus_in.term = q;
      bus_in.sum  = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_a_ff.valid <= 1'b0;
         side_b_ff.valid <= 1'b0;
         side_c_ff.valid <= 1'b0;
      end else if (en) begin
         t_a_ff    <= t_in;
         a_a_ff    <= bus_i.a;
         sum_a_ff  <= bus_i.sum;
         side_a_ff <= side_i;
         t_b_ff    <= t_a_ff;
         qe_b_ff   <= qe_in;
         a_b_ff    <= a_a_ff;
         sum_b_ff  <= sum_a_ff;
         side_b_ff <= side_a_ff;
         bus_c_ff  <= bus_in;
         side_c_ff <= side_b_ff;
      end
   end

   assign bus_o  = bus_c_ff;
   assign side_o = side_c_ff;
endmodule

// ===== rtl/core/rws_square_cell.sv =====
// One squaring cell: e = (e*e + 2^29) >> 30 in Q.30.
module rws_square_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [30:0]       e_i,
   input  rws_pkg::side_type side_i,
   output logic [30:0]       e_o,
   output rws_pkg::side_type side_o
);
   import rws_pkg::*;

   logic [61:0] p;
   logic [30:0] e_ff;
   side_type    side_ff;

   assign p = 62'(e_i) * 62'(e_i) + 62'(32'h2000_0000);

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         e_ff    <= p[60:30];
         side_ff <= side_i;
      end
   end

   assign e_o    = e_ff;
   assign side_o = side_ff;
endmodule

// ===== rtl/core/ricker_wavelet_sample.sv =====
// Ricker wavelet sample generator: index in, Q2.14 amplitude out.
// Pipeline: 5 front stages, 3 per Taylor cell (14 cells), clamp, 4 squarings,
// product and output register between request and result.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on rsp_tready. Reset (synchronous) clears valid bits and restores the
// registers to 30 Hz, about 1 ms step and 1024 samples.
module ricker_wavelet_sample #(
   parameter int MAX_SAMPLES = rws_pkg::MAX_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample_index, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] amplitude
   output logic        rsp_tlast,   // last_sample
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rws_pkg::*;

   localparam int LW = $clog2(MAX_SAMPLES + 1);

   // ---------------- configuration registers ----------------
   logic [17:0] peak_freq_ff;
   logic [31:0] time_step_ff;
   logic [12:0] wavelet_length_ff;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_freq_ff      <= 18'd7680;
         time_step_ff      <= 32'd4294967;
         wavelet_length_ff <= 13'd1024;
      end else if (wr) begin
         unique case (csr_paddr[3:2])
            REG_PEAK_FREQ:      peak_freq_ff      <= csr_pwdata[17:0];
            REG_TIME_STEP:      time_step_ff      <= csr_pwdata;
            REG_WAVELET_LENGTH: wavelet_length_ff <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_PEAK_FREQ:      csr_prdata = {14'd0, peak_freq_ff};
         REG_TIME_STEP:      csr_prdata = time_step_ff;
         REG_WAVELET_LENGTH: csr_prdata = {19'd0, wavelet_length_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // ---------------- pipeline enable ----------------
   logic rsp_valid_ff, en;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- front end ----------------
   // effective length saturates to the sample capacity
   logic [LW-1:0] len;
   logic [11:0]   idx;
   logic          in_range, is_last;

   assign len = (32'(wavelet_length_ff) > 32'(MAX_SAMPLES)) ? LW'(MAX_SAMPLES)
                                                          : LW'(wavelet_length_ff);
   assign idx = req_tdata[11:0];
   assign in_range = (32'(idx) < 32'(len));
   assign is_last  = in_range && (32'(idx) == 32'(len) - 32'd1);

   side_type    side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;
   logic [11:0] idx1_ff;
   logic [49:0] fd1_ff;
   logic [61:0] q2_ff, q2_in;
   logic [49:0] sp;
   logic [25:0] w3_ff;
   logic signed [27:0] x;
   logic [27:0] ax;
   logic [21:0] ax4_ff;
   logic [43:0] sq;
   logic [23:0] a5_ff;
   side_type    side_in, side3_in, side4_in;

   always_comb begin
      side_in       = '0;
      side_in.valid = req_tvalid;
      side_in.last  = is_last;
      side_in.zero  = !in_range;
   end

   assign q2_in = 62'(fd1_ff) * 62'(idx1_ff);
   assign sp    = 50'(q2_ff[43:16]) * 50'(PI_Q20) + 50'(24'h80_0000);
   assign x     = $signed({2'b00, w3_ff}) - $signed(TWO_PI_SQ_Q20);
   assign ax    = x[27] ? 28'(-x) : 28'(x);
   assign sq    = 44'(ax4_ff) * 44'(ax4_ff) + 44'(20'h8_0000);

   always_comb begin
      side3_in      = side2_ff;
      // product of 16.0 or more flushes
      side3_in.zero = side2_ff.zero || (q2_ff[61:44] != '0);
      side4_in      = side3_ff;
      // |x| of 4.0 or more flushes
      side4_in.zero = side3_ff.zero || (ax[27:22] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
         side4_ff.valid <= 1'b0;
         side5_ff.valid <= 1'b0;
      end else if (en) begin
         side1_ff <= side_in;
         idx1_ff  <= idx;
         fd1_ff   <= 50'(peak_freq_ff) * 50'(time_step_ff);
         side2_ff <= side1_ff;
         q2_ff    <= q2_in;
         side3_ff <= side3_in;
         w3_ff    <= sp[49:24];
         side4_ff <= side4_in;
         ax4_ff   <= ax[21:0];
         side5_ff <= side4_ff;
         a5_ff    <= sq[43:20];
      end
   end

   // multiplier 1 - 2a as sign and magnitude
   logic signed [25:0] m;
   side_type     chain_side [SERIES_TERMS+1];
   term_bus_type chain_bus  [SERIES_TERMS+1];

   assign m = $signed(26'h10_0000) - $signed({1'b0, a5_ff, 1'b0});

   always_comb begin
      chain_side[0]      = side5_ff;
      chain_side[0].neg  = m[25];
      chain_side[0].mag  = m[25] ? 25'(-m) : 25'(m);
      chain_bus[0].a     = a5_ff;
      chain_bus[0].term  = ONE_Q30;
      chain_bus[0].sum   = $signed({2'b00, ONE_Q30});
   end

   // ---------------- series of exp(-a/16) ----------------
   for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
      rws_term_cell #(.K(k + 1)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .bus_i  (chain_bus[k]),
         .side_i (chain_side[k]),
         .bus_o  (chain_bus[k+1]),
         .side_o (chain_side[k+1])
      );
   end

   // clamp sum to [0, 1.0]
   logic signed [32:0] sum_end;
   logic [30:0] e_clamp_ff;
   side_type    side_cl_ff;

   assign sum_end = chain_bus[SERIES_TERMS].sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_cl_ff.valid <= 1'b0;
      end else if (en) begin
         side_cl_ff <= chain_side[SERIES_TERMS];
         if (sum_end[32]) begin
            e_clamp_ff <= '0;
         end else if (sum_end > $signed({2'b00, ONE_Q30})) begin
            e_clamp_ff <= ONE_Q30;
         end else begin
            e_clamp_ff <= sum_end[30:0];
         end
      end
   end

   // ---------------- squaring to exp(-a) ----------------
   logic [30:0] sq_e    [SQUARINGS+1];
   side_type    sq_side [SQUARINGS+1];

   assign sq_e[0]    = e_clamp_ff;
   assign sq_side[0] = side_cl_ff;

   for (genvar j = 0; j < SQUARINGS; j++) begin : g_sq
      rws_square_cell u_sq (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .e_i    (sq_e[j]),
         .side_i (sq_side[j]),
         .e_o    (sq_e[j+1]),
         .side_o (sq_side[j+1])
      );
   end

   // ---------------- scale, round and output ----------------
   logic [55:0] prod_ff, prod_rnd;
   side_type    side_p_ff;
   logic [19:0] r;
   logic [14:0] r_cl;
   logic [15:0] amp;
   logic [15:0] rsp_data_ff;
   logic        rsp_last_ff;

   assign prod_rnd = prod_ff + 56'(36'h8_0000_0000);
   assign r        = prod_rnd[55:36];
   assign r_cl     = (r > 20'd16384) ? 15'd16384 : r[14:0];
   assign amp      = side_p_ff.zero ? 16'd0
                   : (side_p_ff.neg ? 16'(-$signed({1'b0, r_cl})) : {1'b0, r_cl});

   always_ff @(posedge clock) begin
      if (reset) begin
         side_p_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else if (en) begin
         side_p_ff   <= sq_side[SQUARINGS];
         prod_ff     <= 56'(sq_side[SQUARINGS].mag) * 56'(sq_e[SQUARINGS]);
         rsp_valid_ff <= side_p_ff.valid;
         rsp_data_ff <= amp;
         rsp_last_ff <= side_p_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

// ===== dv/ricker_wavelet_sample_tb.sv =====
// Testbench for the Ricker wavelet sample generator: stream stimulus, APB setup, self-check.
module ricker_wavelet_sample_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rws_pkg::*;

   // Holds the amplitudes still owed by the block and compares each returned sample.
   class ricker_scoreboard;
      logic [15:0] amp_due[$];
      logic        last_due[$];
      int          errors = 0;

      function void note_request(logic [15:0] amp, logic last);
         amp_due.push_back(amp);
         last_due.push_back(last);
      endfunction

      function void check_sample(logic [15:0] amp, logic last);
         logic [15:0] amp_exp;
         logic        last_exp;
         if (amp_due.size() == 0) begin
            $display("%0t: unexpected sample amp=%0d last=%0b", $time, $signed(amp), last);
            errors++;
            return;
         end
         amp_exp  = amp_due.pop_front();
         last_exp = last_due.pop_front();
         if (amp !== amp_exp) begin
            $display("%0t: amplitude expected %0d actual %0d", $time, $signed(amp_exp),
                     $signed(amp));
            errors++;
         end
         if (last !== last_exp) begin
            $display("%0t: last_sample expected %0b actual %0b", $time, last_exp, last);
            errors++;
         end
      endfunction

      function int pending();
         return amp_due.size();
      endfunction
   endclass

   // Pipeline depth given in the block header; used for the quiet period.
   localparam int PIPE_LATENCY = 54;
   localparam int NUM_RANDOM   = 1625;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [11:0] sample_index, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] amplitude
   logic        rsp_tlast;   // last_sample
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ricker_wavelet_sample u_dut (.*);

   // Local copy of the configuration registers.
   logic [17:0] cfg_freq;
   logic [31:0] cfg_step;
   logic [12:0] cfg_len;

   ricker_scoreboard sb;
   bit stall_enable;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // No gap most of the time, a short one often, an occasional long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // exp(-a) in Q.30, a in Q.20: Taylor series on a/16, then four squarings.
   function automatic logic [63:0] exp_neg(logic [63:0] a);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        e;
      term = 64'd1 << 30;
      sum  = 64'sd1 << 30;
      for (int k = 1; k <= 14; k++) begin
         term = (term * a) >> 24;
         term = term / k;
         if (k % 2 == 1) sum = sum - $signed(term);
         else            sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
      e = sum;
      for (int k = 0; k < 4; k++)
         e = (e * e + (64'd1 << 29)) >> 30;
      return e;
   endfunction

   function automatic logic [15:0] wavelet_amp(logic [11:0] idx);
      logic [63:0]        q, s, w, ax, a, e, mag, r;
      logic signed [63:0] x, m;
      q = 64'(cfg_freq) * 64'(cfg_step) * 64'(idx);
      if (q >= (64'd1 << 44)) return 16'd0;
      s = q >> 16;
      w = (s * 64'd3294199 + (64'd1 << 23)) >> 24;
      x = $signed(w) - 64'sd20698061;
      ax = (x < 0) ? -x : x;
      if (ax >= (64'd4 << 20)) return 16'd0;
      a = (ax * ax + (64'd1 << 19)) >> 20;
      e = exp_neg(a);
      m = (64'sd1 << 20) - 2 * $signed(a);
      mag = (m < 0) ? -m : m;
      r = (mag * e + (64'd1 << 35)) >> 36;
      if (r > 16384) r = 16384;
      return (m < 0) ? 16'(-r) : 16'(r);
   endfunction

   // Predict the returned sample for one index under the current settings.
   task automatic predict_sample(logic [11:0] idx);
      logic [13:0] len;
      len = (cfg_len > 4096) ? 14'd4096 : 14'(cfg_len);
      if (idx < len) sb.note_request(wavelet_amp(idx), idx == len - 1);
      else           sb.note_request(16'd0, 1'b0);
   endtask

   // Valid stays high into the next request when there is no gap.
   task automatic send_index(logic [11:0] idx);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_sample(idx);
   endtask

   task automatic csr_write(logic [1:0] reg_sel, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (reg_sel)
         REG_PEAK_FREQ:      cfg_freq = value[17:0];
         REG_TIME_STEP:      cfg_step = value;
         REG_WAVELET_LENGTH: cfg_len  = value[12:0];
         default: ;
      endcase
   endtask

   // Wait out every owed sample, then the pipeline depth so the block is idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
   endtask

   task automatic setup(logic [17:0] f, logic [31:0] dt, logic [12:0] len);
      csr_write(REG_PEAK_FREQ, 32'(f));
      csr_write(REG_TIME_STEP, dt);
      csr_write(REG_WAVELET_LENGTH, 32'(len));
   endtask

   // Random index: mostly within the wavelet, sometimes the last sample, some anywhere.
   function automatic logic [11:0] pick_index();
      int r;
      logic [13:0] len;
      len = (cfg_len > 4096) ? 14'd4096 : 14'(cfg_len);
      r = $urandom_range(0, 9);
      if (r < 6 && len > 0) return 12'($urandom_range(0, len - 1));
      if (r < 7 && len > 0) return 12'(len - 1);
      return 12'($urandom_range(0, 4095));
   endfunction

   // Result side: random stalls while stall_enable is set, checked on each handshake.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_sample(rsp_tdata, rsp_tlast);
   end

   initial begin
      int g;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!stall_enable) rsp_tready <= 1'b1;
         else begin
            g = gap_len();
            if (g == 0) rsp_tready <= 1'b1;
            else begin
               rsp_tready <= 1'b0;
               repeat (g) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      sb = new();
      stall_enable = 1'b1;
      cfg_freq = 18'd7680;
      cfg_step = 32'd4294967;
      cfg_len  = 13'd1024;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, index extremes, an early index, the last sample.
      send_index(12'd0);
      send_index(12'd66);
      send_index(12'd1022);
      send_index(12'd1023);
      send_index(12'd1024);
      send_index(12'd4095);
      send_index(12'hAAA);
      send_index(12'h555);
      // Pause until everything is back before touching the registers.
      drain();
      // Zero length: nothing inside, no last flag.
      setup(18'd7680, 32'd4294967, 13'd0);
      send_index(12'd0);
      send_index(12'd4095);
      drain();
      // Length over the limit saturates to the maximum.
      setup(18'h3FFFF, 32'd1, 13'h1FFF);
      send_index(12'd4095);
      send_index(12'd0);
      drain();
      // Largest frequency and step: product overflows the range, flush to zero.
      setup(18'h3FFFF, 32'hFFFF_FFFF, 13'd4096);
      send_index(12'd1);
      send_index(12'd4095);
      drain();
      // Smallest settings: x stays near -2 pi^2, flush to zero; length of one.
      setup(18'd1, 32'd1, 13'd1);
      send_index(12'd0);
      send_index(12'd1);
      drain();
      // Unused register address is ignored.
      csr_write(2'd3, 32'hFFFF_FFFF);
      setup(18'd7680, 32'd4294967, 13'd1024);
      send_index(12'd66);
      send_index(12'd40);
      send_index(12'd90);
      drain();

      // Random phases, each with its own settings drawn from one of four kinds.
      for (int p = 0; p < 13; p++) begin
         case (p % 4)
            0: setup(18'd7680, 32'd4294967, 13'($urandom_range(1, 4096)));
            1: setup(18'($urandom_range(1, 262143)), $urandom(),
                     13'($urandom_range(0, 8191)));
            2: setup(18'($urandom_range(256, 25600)),
                     32'($urandom_range(100000, 50000000)), 13'($urandom_range(64, 4096)));
            default: setup(18'($urandom_range(1280, 12800)), 32'd4294967, 13'd4096);
         endcase
         stall_enable = (p % 5 != 3);
         for (int n = 0; n < NUM_RANDOM / 13; n++)
            send_index(pick_index());
         drain();
      end

      if (sb.errors == 0)
         $display("ricker_wavelet_sample test passed");
      else
         $display("ricker_wavelet_sample test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("ricker_wavelet_sample test failed");
      $finish;
   end

endmodule
